// File: hw/rtl/chbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and codes of the canonical Huffman bit decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  localparam int NUM_LEN = 16;  // rows of the per-length tables
  localparam int LEN_IW  = 4;   // index width of the per-length tables

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_CLEAR  = 3'd0;
  localparam opcode_t OP_COUNT  = 3'd1;
  localparam opcode_t OP_SYMBOL = 3'd2;
  localparam opcode_t OP_FINISH = 3'd3;
  localparam opcode_t OP_DECODE = 3'd4;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_SYMBOL   = 3'd1;
  localparam status_t ST_INVALID  = 3'd2;
  localparam status_t ST_NOTBUILT = 3'd3;
  localparam status_t ST_OVERFULL = 3'd4;
  localparam status_t ST_MISMATCH = 3'd5;

  // Table write issued by the build walk, one length per cycle.
  typedef struct packed {
    logic        we;
    logic [16:0] first;
    logic [8:0]  offset;
  } walk_wr_t;

  // End of the build walk.
  typedef struct packed {
    logic        done;
    status_t     status;
    logic [15:0] last;
    logic [4:0]  longest;
  } walk_fin_t;

endpackage

// File: hw/rtl/canonical_huffman_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder
// Builds a canonical Huffman table from per-length code counts and a symbol
// list, then decodes a code stream fed one bit per word.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  command  | start in, busy out     | opcode level count symbol_index symbol
//           | taken when start&!busy | value_total bit_req
//  result   | done out, one cycle    | status decoded_symbol code_length
//
//  A word other than finish is taken and shows its result on done in the
//  next cycle; busy stays high through done, so words never overlap. Finish
//  runs the build walk, one code length per cycle, which stops early when it
//  fails; done follows its end. The symbol store is a synchronous RAM; a
//  decode word reads it at the accept edge and the symbol appears with done.
//  Reset is synchronous and clears the tables and the control state; the
//  symbol RAM keeps its contents and needs no clearing pass.
//  The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder #(
  parameter int MAX_CODE_LENGTH = 16,
  parameter int MAX_SYMBOLS     = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  chbd_pkg::opcode_t opcode,
  input  logic [4:0]        level,
  input  logic [7:0]        count,
  input  logic [7:0]        symbol_index,
  input  logic [7:0]        symbol,
  input  logic [8:0]        value_total,
  input  logic              bit_req,
  output logic              done,
  output chbd_pkg::status_t status,
  output logic [7:0]        decoded_symbol,
  output logic [4:0]        code_length
);
  import chbd_pkg::*;

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // per-length tables, small enough to live in flops
  logic [7:0]  counts    [NUM_LEN];
  logic [16:0] first_tab [NUM_LEN];
  logic [8:0]  offset_tab[NUM_LEN];
  logic [15:0] last_code;
  logic [4:0]  longest;
  logic        ready;
  logic [15:0] pcode;
  logic [4:0]  plen;

  // symbol RAM, undefined until written
  logic [7:0] sym_ram[MAX_SYMBOLS];
  logic [7:0] sym_rd;

  // response holding registers
  status_t    rsp_status;
  logic [4:0] rsp_len;
  logic       rsp_sym;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // Build walk
  // --------------------------------------------------------------------------
  logic [LEN_IW-1:0] walk_idx;
  walk_wr_t          walk_wr;
  walk_fin_t         walk_fin;

  chbd_build_walk #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .MAX_SYMBOLS    (MAX_SYMBOLS)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .go   (accept && (opcode == OP_FINISH)),
    .total(value_total),
    .n    (counts[walk_idx]),
    .idx  (walk_idx),
    .wr   (walk_wr),
    .fin  (walk_fin)
  );

  // --------------------------------------------------------------------------
  // Decode step: extend the partial code by one bit and classify it
  // --------------------------------------------------------------------------
  logic [4:0]        dl;
  logic [16:0]       dp;
  logic [4:0]        shamt;
  logic [16:0]       lim;
  logic [LEN_IW-1:0] dk;
  logic [16:0]       rel;
  logic [16:0]       pos;
  logic              bad_bit;
  logic              hit;
  logic              lvl_ok;
  logic [LEN_IW-1:0] lvl_idx;

  always_comb begin
    dl      = plen + 5'd1;
    dp      = {pcode, bit_req};
    shamt   = longest - dl;
    lim     = {1'b0, last_code} >> shamt;
    dk      = plen[LEN_IW-1:0];
    rel     = dp - first_tab[dk];
    pos     = {8'd0, offset_tab[dk]} + rel;
    bad_bit = (dl > longest) || (dp > lim);
    hit     = (dp >= first_tab[dk]) && (rel < {9'd0, counts[dk]});
    lvl_ok  = (level >= 5'd1) && (level <= 5'(MAX_CODE_LENGTH));
    lvl_idx = LEN_IW'(level - 5'd1);
  end

  // read the symbol RAM at the accept edge; write on a symbol load
  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_SYMBOL) && ({1'b0, symbol_index} < 9'(MAX_SYMBOLS))) begin
      sym_ram[symbol_index[AW-1:0]] <= symbol;
    end
    if (accept) begin
      sym_rd <= sym_ram[pos[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = (opcode == OP_FINISH) ? S_WALK : S_RESP;
      end
      S_WALK: begin
        if (walk_fin.done) state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEN; i++) begin
        counts[i]     <= '0;
        first_tab[i]  <= '0;
        offset_tab[i] <= '0;
      end
      last_code <= '0;
      longest   <= '0;
      ready     <= 1'b0;
      pcode     <= '0;
      plen      <= '0;
    end else begin
      // the walk writes derived rows as it goes; they only count once ready
      if (walk_wr.we) begin
        first_tab[walk_idx]  <= walk_wr.first;
        offset_tab[walk_idx] <= walk_wr.offset;
      end
      if (walk_fin.done) begin
        if (walk_fin.status == ST_OK) begin
          last_code <= walk_fin.last;
          longest   <= walk_fin.longest;
          ready     <= 1'b1;
          pcode     <= '0;
          plen      <= '0;
        end else begin
          ready <= 1'b0;
        end
      end
      if (accept) begin
        unique case (opcode)
          OP_CLEAR: begin
            for (int i = 0; i < NUM_LEN; i++) begin
              counts[i]     <= '0;
              first_tab[i]  <= '0;
              offset_tab[i] <= '0;
            end
            last_code <= '0;
            longest   <= '0;
            ready     <= 1'b0;
            pcode     <= '0;
            plen      <= '0;
          end
          OP_COUNT: begin
            ready <= 1'b0;
            pcode <= '0;
            plen  <= '0;
            if (lvl_ok) counts[lvl_idx] <= count;
          end
          OP_SYMBOL: begin
            ready <= 1'b0;
            pcode <= '0;
            plen  <= '0;
          end
          OP_DECODE: begin
            // hold the partial code on a bad bit, drop it on a hit
            if (ready && !bad_bit) begin
              if (hit) begin
                pcode <= '0;
                plen  <= '0;
              end else begin
                pcode <= dp[15:0];
                plen  <= dl;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // response registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= ST_OK;
      rsp_len    <= '0;
      rsp_sym    <= 1'b0;
      if (opcode == OP_DECODE) begin
        priority if (!ready) begin
          rsp_status <= ST_NOTBUILT;
        end else if (bad_bit) begin
          rsp_status <= ST_INVALID;
        end else if (hit) begin
          rsp_status <= ST_SYMBOL;
          rsp_len    <= dl;
          rsp_sym    <= (pos < 17'(MAX_SYMBOLS));
        end else begin
          rsp_status <= ST_OK;
        end
      end
    end else if (walk_fin.done) begin
      rsp_status <= walk_fin.status;
    end
  end

  assign done           = (state == S_RESP);
  assign status         = done ? rsp_status : ST_OK;
  assign code_length    = done ? rsp_len : 5'd0;
  assign decoded_symbol = (done && rsp_sym) ? sym_rd : 8'd0;

endmodule

// File: hw/rtl/chbd_build_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_build_walk
// Walks the code lengths one per cycle, assigning canonical first codes and
// symbol offsets, and checks value count and code space on the way.
// ----------------------------------------------------------------------------
module chbd_build_walk #(
  parameter int MAX_CODE_LENGTH = 16,
  parameter int MAX_SYMBOLS     = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [8:0]                   total,
  input  logic [7:0]                   n,
  output logic [chbd_pkg::LEN_IW-1:0]  idx,
  output chbd_pkg::walk_wr_t           wr,
  output chbd_pkg::walk_fin_t          fin
);
  import chbd_pkg::*;

  logic              active;
  logic [LEN_IW-1:0] k;
  logic [17:0]       code;
  logic [8:0]        used;
  logic [8:0]        tot;
  logic [15:0]       last;
  logic [4:0]        longest;

  logic [4:0]  len;
  logic [17:0] space;
  logic [8:0]  kv;
  logic [17:0] ko;
  logic [17:0] code_sum;
  logic [9:0]  used_sum;
  logic        fail;
  logic        last_len;
  logic [17:0] last_code_next;
  logic [4:0]  longest_next;

  always_comb begin
    len      = {1'b0, k} + 5'd1;
    space    = 18'd1 << len;
    kv       = (used < tot) ? (tot - used) : 9'd0;
    ko       = (code < space) ? (space - code) : 18'd0;
    code_sum = code + {10'd0, n};
    used_sum = {1'b0, used} + {2'd0, n};
    fail     = (kv < {1'b0, n}) || (ko < {10'd0, n});
    last_len = (k == LEN_IW'(MAX_CODE_LENGTH - 1));
    if (n != 8'd0) begin
      last_code_next = code_sum - 18'd1;
      longest_next   = len;
    end else begin
      last_code_next = {2'd0, last};
      longest_next   = longest;
    end
  end

  assign idx       = k;
  assign wr.we     = active;
  assign wr.first  = code[16:0];
  assign wr.offset = used;

  always_comb begin
    fin.done    = active && (fail || last_len);
    fin.last    = last_code_next[15:0];
    fin.longest = longest_next;
    priority if (fail) begin
      fin.status = ({9'd0, kv} <= ko) ? ST_MISMATCH : ST_OVERFULL;
    end else if (used_sum != {1'b0, tot}) begin
      fin.status = ST_MISMATCH;
    end else begin
      fin.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (go) begin
      active <= 1'b1;
    end else if (fin.done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      k       <= '0;
      code    <= '0;
      used    <= '0;
      last    <= '0;
      longest <= '0;
      // a total beyond the symbol store is clamped to one past its size
      tot     <= (total > 9'(MAX_SYMBOLS)) ? 9'(MAX_SYMBOLS + 1) : total;
    end else if (active) begin
      k       <= k + LEN_IW'(1);
      code    <= code_sum << 1;
      used    <= used_sum[8:0];
      last    <= last_code_next[15:0];
      longest <= longest_next;
    end
  end

endmodule

// File: hw/rtl/chbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks of the canonical Huffman bit decoder.
// ----------------------------------------------------------------------------
module chbd_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input chbd_pkg::status_t status,
  input logic [7:0]        decoded_symbol,
  input logic [4:0]        code_length
);
  import chbd_pkg::*;

  // a result only shows while the word is still in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe without busy");

  // every accepted word raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  // busy drops only right after a result was delivered
  a_release: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done)) else $error("busy dropped without a result");

  // symbol and length only on a completed code
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_SYMBOL)) |-> (decoded_symbol == 8'd0 && code_length == 5'd0))
    else $error("symbol fields set without a completed code");

  a_len: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_SYMBOL)) |-> (code_length != 5'd0 && code_length <= 5'd16))
    else $error("completed code has a bad length");

endmodule

bind canonical_huffman_bit_decoder chbd_checker u_chbd_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .decoded_symbol(decoded_symbol),
  .code_length   (code_length)
);

// File: bench/huffman_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_result_checker
// Watches the command and result channels of the canonical Huffman bit
// decoder, predicts each result from its own copy of the tables and compares.
// ----------------------------------------------------------------------------
module huffman_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  chbd_pkg::opcode_t opcode,
  input  logic [4:0]        level,
  input  logic [7:0]        count,
  input  logic [7:0]        symbol_index,
  input  logic [7:0]        symbol,
  input  logic [8:0]        value_total,
  input  logic              bit_req,
  input  logic              done,
  input  chbd_pkg::status_t status,
  input  logic [7:0]        decoded_symbol,
  input  logic [4:0]        code_length,
  output int                errors,
  output int                pending
);
  import chbd_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [7:0] sym;
    logic [4:0] len;
  } huff_result_t;

  huff_result_t expected_results[$];

  logic [7:0]  len_count  [16];
  logic [7:0]  sym_store  [256];
  logic [16:0] first_code [16];
  logic [8:0]  sym_offset [16];
  logic [15:0] last_code;
  logic [4:0]  longest;
  logic        ready;
  logic [15:0] part_code;
  logic [4:0]  part_len;
  int          err_cnt = 0;

  task automatic clear_tables();
    for (int i = 0; i < 16; i++) begin
      len_count[i]  = '0;
      first_code[i] = '0;
      sym_offset[i] = '0;
    end
    last_code = '0;
    longest   = '0;
    ready     = 1'b0;
    part_code = '0;
    part_len  = '0;
  endtask

  // Assign codes per length; a failure names the tighter budget, value count on a tie.
  task automatic walk_code_lengths(input logic [8:0] total_in, output status_t st);
    int unsigned fc [16];
    int unsigned so [16];
    int unsigned code, used, lastc, lng, tot, n, space, kv, ko;
    code  = 0;
    used  = 0;
    lastc = 0;
    lng   = 0;
    tot   = (total_in > 9'd256) ? 257 : 32'(total_in);
    st    = ST_OK;
    for (int l = 1; l <= 16; l++) begin
      n     = 32'(len_count[l-1]);
      space = 1 << l;
      kv    = (used < tot) ? tot - used : 0;
      ko    = (code < space) ? space - code : 0;
      fc[l-1] = code;
      so[l-1] = used;
      if (kv < n || ko < n) begin
        st = (kv <= ko) ? ST_MISMATCH : ST_OVERFULL;
        return;
      end
      if (n != 0) begin
        lastc = code + n - 1;
        lng   = l;
      end
      code = (code + n) << 1;
      used += n;
    end
    if (used != tot) begin
      st = ST_MISMATCH;
      return;
    end
    for (int i = 0; i < 16; i++) begin
      first_code[i] = fc[i][16:0];
      sym_offset[i] = so[i][8:0];
    end
    last_code = lastc[15:0];
    longest   = lng[4:0];
    ready     = 1'b1;
    part_code = '0;
    part_len  = '0;
  endtask

  task automatic predict_huffman_result(output huff_result_t r);
    int unsigned l, p, rel, pos;
    status_t st;
    r = '0;
    case (opcode)
      OP_CLEAR: clear_tables();
      OP_COUNT, OP_SYMBOL: begin
        ready     = 1'b0;
        part_code = '0;
        part_len  = '0;
        if (opcode == OP_COUNT) begin
          if (level >= 5'd1 && level <= 5'd16) len_count[level-1] = count;
        end else begin
          sym_store[symbol_index] = symbol;
        end
      end
      OP_FINISH: begin
        walk_code_lengths(value_total, st);
        if (st != ST_OK) ready = 1'b0;
        r.status = st;
      end
      OP_DECODE: begin
        if (!ready) begin
          r.status = ST_NOTBUILT;
        end else begin
          l = part_len + 1;
          p = (int'(part_code) << 1) | bit_req;
          if (l > longest) begin
            r.status = ST_INVALID;
          end else if (p > (int'(last_code) >> (longest - l))) begin
            r.status = ST_INVALID;
          end else begin
            rel = p - first_code[l-1];
            if (p >= first_code[l-1] && rel < len_count[l-1]) begin
              pos      = sym_offset[l-1] + rel;
              r.status = ST_SYMBOL;
              r.sym    = (pos < 256) ? sym_store[pos] : 8'd0;
              r.len    = l[4:0];
              part_code = '0;
              part_len  = '0;
            end else begin
              part_code = p[15:0];
              part_len  = l[4:0];
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    huff_result_t r;
    if (rst) begin
      clear_tables();
      expected_results.delete();
    end else begin
      // retire the older word first; busy stays high while its result shows
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word expected none actual status %0d symbol %0d length %0d",
                   $time, status, decoded_symbol, code_length);
          err_cnt++;
        end else begin
          r = expected_results.pop_front();
          compare_field("status", 32'(r.status), 32'(status));
          compare_field("decoded_symbol", 32'(r.sym), 32'(decoded_symbol));
          compare_field("code_length", 32'(r.len), 32'(code_length));
        end
      end
      if (start && !busy) begin
        predict_huffman_result(r);
        expected_results.push_back(r);
      end
    end
    pending <= expected_results.size();
    errors  <= err_cnt;
  end

endmodule

// File: bench/tb_canonical_huffman_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canonical_huffman_bit_decoder
// Drives command words into the canonical Huffman bit decoder: a directed
// pass over the special cases, a full symbol store fill, then random table
// builds each followed by a stream of code bits, mixed with noise words.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_canonical_huffman_bit_decoder;
  import chbd_pkg::*;

  localparam int ITEMS       = 2000;
  localparam int STALL_LIMIT = 1000;  // quiet cycles before the run is given up
  localparam int TAIL_CYCLES = 40;    // a failed-early build walk plus margin

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       start        = 1'b0;
  opcode_t    opcode       = OP_CLEAR;
  logic [4:0] level        = '0;
  logic [7:0] count        = '0;
  logic [7:0] symbol_index = '0;
  logic [7:0] symbol       = '0;
  logic [8:0] value_total  = '0;
  logic       bit_req      = 1'b0;
  logic       busy;
  logic       done;
  status_t    status;
  logic [7:0] decoded_symbol;
  logic [4:0] code_length;

  int errors;
  int pending;
  int words_sent   = 0;
  int stall_cycles = 0;
  bit idle_ok      = 1'b1;

  canonical_huffman_bit_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .level          (level),
    .count          (count),
    .symbol_index   (symbol_index),
    .symbol         (symbol),
    .value_total    (value_total),
    .bit_req        (bit_req),
    .done           (done),
    .status         (status),
    .decoded_symbol (decoded_symbol),
    .code_length    (code_length)
  );

  huffman_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .level          (level),
    .count          (count),
    .symbol_index   (symbol_index),
    .symbol         (symbol),
    .value_total    (value_total),
    .bit_req        (bit_req),
    .done           (done),
    .status         (status),
    .decoded_symbol (decoded_symbol),
    .code_length    (code_length),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one word and hold it until the block takes it. Start stays high
  // across back-to-back words; it only drops for an idle burst.
  task automatic send_word(input int op, input int lv, input int cn,
                           input int ix, input int sy,
                           input int tot, input int b);
    int gap;
    gap = 0;
    if (idle_ok && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op[2:0];
    level        <= lv[4:0];
    count        <= cn[7:0];
    symbol_index <= ix[7:0];
    symbol       <= sy[7:0];
    value_total  <= tot[8:0];
    bit_req      <= b[0];
    @(posedge clk);
    while (busy) @(posedge clk);
    // unused opcodes do nothing, so leave them out of the word budget
    if (op[2:0] <= OP_DECODE) words_sent++;
  endtask

  // Fields that an opcode does not look at carry random values.
  task automatic send_count(input int lv, input int cn);
    send_word(int'(OP_COUNT), lv, cn, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_symbol(input int ix, input int sy);
    send_word(int'(OP_SYMBOL), $urandom, $urandom, ix, sy, $urandom, $urandom);
  endtask

  task automatic send_finish(input int tot);
    send_word(int'(OP_FINISH), $urandom, $urandom, $urandom, $urandom, tot, $urandom);
  endtask

  task automatic send_decode(input int b);
    send_word(int'(OP_DECODE), $urandom, $urandom, $urandom, $urandom, $urandom, b);
  endtask

  task automatic send_noise();
    send_word($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
  endtask

  // One table session: grow a random prefix code by splitting leaves, load it,
  // finish (sometimes broken on purpose), then stream random code bits.
  task automatic run_table_session();
    int cnt [17];
    int leaves, target, d, tries, total, k, rot, nbits;
    bit cleared, broken;
    for (int i = 0; i <= 16; i++) cnt[i] = 0;
    case ($urandom_range(0, 9))
      0:       target = 1;
      1:       target = $urandom_range(60, 256);
      default: target = $urandom_range(2, 24);
    endcase
    if (target == 1) begin
      cnt[1] = 1;
      leaves = 1;
    end else begin
      cnt[1] = 2;
      leaves = 2;
    end
    tries = 0;
    while (leaves < target && tries < 4000) begin
      tries++;
      d = $urandom_range(1, 15);
      if (cnt[d] > 0 && cnt[d+1] <= 253) begin
        cnt[d]--;
        cnt[d+1] += 2;
        leaves++;
      end
    end
    // drop a leaf now and then so some bit paths fit no code
    if (leaves > 1 && $urandom_range(0, 3) == 0) begin
      d = $urandom_range(1, 16);
      while (cnt[d] == 0) d = $urandom_range(1, 16);
      cnt[d]--;
      leaves--;
    end
    total   = leaves;
    broken  = ($urandom_range(0, 9) == 0);
    cleared = $urandom_range(0, 1);
    if (cleared) send_word(int'(OP_CLEAR), $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
    // load the counts starting at a random length; after a clear skip the zeros
    rot = $urandom_range(0, 15);
    for (int i = 0; i < 16; i++) begin
      d = ((i + rot) % 16) + 1;
      if (!cleared || cnt[d] != 0) send_count(d, cnt[d]);
    end
    k = (total < 6) ? total : 6;
    k = $urandom_range(0, k);
    for (int i = 0; i < k; i++) send_symbol($urandom_range(0, total - 1), $urandom);
    if (broken) begin
      case ($urandom_range(0, 3))
        0: begin
          d = $urandom_range(1, 16);
          if (cnt[d] < 255) send_count(d, cnt[d] + 1);
          send_finish(total);
        end
        1:       send_finish(total + 1);
        2:       send_finish(total - 1);
        default: send_finish($urandom_range(257, 511));
      endcase
    end else begin
      send_finish(total);
    end
    nbits = $urandom_range(10, 60);
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(0, 39) == 0) send_noise();
      else send_decode($urandom_range(0, 1));
    end
  endtask

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_canonical_huffman_bit_decoder: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Decode before any build is refused.
    send_decode(1);
    // Empty table builds, and then every bit is invalid.
    send_finish(0);
    send_decode(0);
    // Levels zero and above sixteen are dropped.
    send_count(0, 255);
    send_count(17, 1);
    // Codes 0, 10, 110, 111.
    send_count(1, 1);
    send_count(2, 1);
    send_count(3, 2);
    send_symbol(0, 'h00);
    send_symbol(1, 'hFF);
    send_symbol(2, 'hA5);
    send_symbol(3, 'h5A);
    send_finish(4);
    send_decode(0);
    send_decode(1);
    send_decode(1);
    send_decode(0);
    // A load after the build drops the table until the next finish.
    send_count(3, 0);
    send_decode(1);
    // Two codes left: a total of four mismatches, two builds.
    send_finish(4);
    send_finish(2);
    // 11 fits no code; the partial 1 is kept, so 0 completes 10.
    send_decode(1);
    send_decode(1);
    send_decode(0);
    // Three codes of length one overflow the code space.
    send_count(1, 3);
    send_finish(3);
    // After a clear, the largest count at the longest length; a total beyond
    // the symbol store does not match it.
    send_word(int'(OP_CLEAR), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    send_count(16, 255);
    send_finish(511);
    send_finish(255);
    // Unused opcodes.
    send_word($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    send_word($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);

    // Fill the whole symbol store so no later decode can read an unwritten entry.
    for (int i = 0; i < 256; i++) send_symbol(i, $urandom);

    while (words_sent < ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        run_table_session();
      end
      if (words_sent > ITEMS - 300) idle_ok = 1'b0;
      else if ($urandom_range(0, 4) == 0) idle_ok = !idle_ok;
    end

    start <= 1'b0;
    // pending is a registered copy of the checker's queue size
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_canonical_huffman_bit_decoder: clean");
    end else begin
      $display("tb_canonical_huffman_bit_decoder: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/chbd_pkg.sv
hw/rtl/chbd_build_walk.sv
hw/rtl/canonical_huffman_bit_decoder.sv
hw/rtl/chbd_checker.sv
bench/huffman_result_checker.sv
bench/tb_canonical_huffman_bit_decoder.sv
